// File: rtl/bpm_pkg.sv
// Package for the body posture monitor: payload word types, register
// indexes, reset values and code constants. No dependencies.
`default_nettype none
package bpm_pkg;

    localparam int DEF_TILT_WINDOW   = 16;
    localparam int DEF_CHARGE_WINDOW = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLEN_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGING_CURRENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_DELAY_IDLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_DELAY_WALKING = 3'd4;

    localparam logic [14:0]        RST_UPRIGHT_LIMIT    = 15'd2048;
    localparam logic [14:0]        RST_FALLEN_LIMIT     = 15'd4915;
    localparam logic signed [15:0] RST_CHARGING_CURRENT = 16'sd0;
    localparam logic [15:0]        RST_LIFT_DELAY       = 16'd1000;

    localparam logic signed [15:0] DISCHARGE_LIMIT = -16'sd500;

    localparam logic [1:0] MOTION_WALK  = 2'd1;
    localparam logic [1:0] MOTION_STAND = 2'd2;

    localparam logic [2:0] POSTURE_UNDEFINED = 3'd0;
    localparam logic [2:0] POSTURE_UPRIGHT   = 3'd1;
    localparam logic [2:0] POSTURE_LEFT      = 3'd2;
    localparam logic [2:0] POSTURE_RIGHT     = 3'd3;
    localparam logic [2:0] POSTURE_BACK      = 3'd4;
    localparam logic [2:0] POSTURE_FRONT     = 3'd5;

    localparam int CHARGE_W = 12;

    typedef struct packed {
        logic signed [15:0]    tilt_x;
        logic signed [15:0]    tilt_y;
        logic                  left_contact;
        logic                  right_contact;
        logic [31:0]           frame_time;
        logic [1:0]            motion_kind;
        logic                  goal_met;
        logic signed [15:0]    battery_current;
        logic [CHARGE_W-1:0]   battery_charge;
    } t_in_word;

    typedef struct packed {
        logic [2:0]            posture;
        logic [31:0]           posture_since;
        logic                  left_standing;
        logic                  right_standing;
        logic [31:0]           contact_since;
        logic                  lifted;
        logic                  walk_ready;
        logic                  discharging;
        logic                  charging;
        logic [CHARGE_W-1:0]   charge_level;
    } t_out_word;

endpackage
`default_nettype wire

// File: rtl/body_posture_monitor.sv
// Body posture monitor: tilt and charge window memories, posture classes,
// contact and lift timing, battery flags and charge average.
// Depends on bpm_pkg.
`default_nettype none
// One sensor word is taken while the block is idle; it then passes through
// S_SUM, S_MUL and S_CLASS to S_DONE, which loads its result word into the
// output register and then returns the block to S_IDLE. The next word can be
// taken while the previous result still waits in the output register; a
// result that finds that register still full holds the block until the
// waiting word leaves. The charge average is a reciprocal multiplication by
// the window length. The tilt and charge windows sit in two single-port
// synchronous memories read at the ring slot and written back with the new
// sample.
module body_posture_monitor #(
    parameter int TILT_WINDOW   = bpm_pkg::DEF_TILT_WINDOW,
    parameter int CHARGE_WINDOW = bpm_pkg::DEF_CHARGE_WINDOW
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire bpm_pkg::t_in_word               i_in_word,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output      bpm_pkg::t_out_word              o_out_word,
    input  wire logic                            i_cfg_we,
    input  wire logic [bpm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bpm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bpm_pkg::*;

    localparam int TA_W  = (TILT_WINDOW > 1) ? $clog2(TILT_WINDOW) : 1;
    localparam int TC_W  = $clog2(TILT_WINDOW + 1);
    localparam int TS_W  = 16 + $clog2(TILT_WINDOW);
    localparam int LP_W  = 15 + TC_W;
    localparam int CMP_W = ((TS_W > LP_W) ? TS_W : LP_W) + 1;
    localparam int CA_W  = (CHARGE_WINDOW > 1) ? $clog2(CHARGE_WINDOW) : 1;
    localparam int CC_W  = $clog2(CHARGE_WINDOW + 1);
    localparam int CS_W  = CHARGE_W + $clog2(CHARGE_WINDOW);
    localparam int DV_SH = CS_W + $clog2(CHARGE_WINDOW);
    localparam int PR_W  = 2 * CS_W + 1;
    localparam longint DV_MUL_L = ((longint'(1) << DV_SH) + longint'(CHARGE_WINDOW) - 1)
                                  / longint'(CHARGE_WINDOW);
    localparam logic [CS_W:0] DV_MUL = DV_MUL_L[CS_W:0];

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUM   = 5'b00010,
        S_MUL   = 5'b00100,
        S_CLASS = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;

    logic [14:0]        r_upright_limit;
    logic [14:0]        r_fallen_limit;
    logic signed [15:0] r_charging_current;
    logic [15:0]        r_delay_idle;
    logic [15:0]        r_delay_walking;

    logic [31:0]        r_tilt_mem [TILT_WINDOW];
    logic [CHARGE_W-1:0] r_charge_mem [CHARGE_WINDOW];
    logic [31:0]        r_tilt_rd;
    logic [CHARGE_W-1:0] r_charge_rd;

    t_in_word           r_in;
    logic signed [TS_W-1:0] r_xsum, r_ysum, n_xsum, n_ysum;
    logic [TC_W-1:0]    r_tcnt;
    logic [TA_W-1:0]    r_tslot;
    logic [CS_W-1:0]    r_csum, n_csum;
    logic [CC_W-1:0]    r_ccnt;
    logic [CA_W-1:0]    r_cslot;
    logic [2:0]         r_held_posture;
    logic [31:0]        r_posture_stamp;
    logic               r_left_held, r_right_held;
    logic [31:0]        r_contact_stamp;

    logic [LP_W-1:0]    r_up_n, r_fa_n;
    logic [PR_W-1:0]    r_cprod;

    t_out_word          r_res;
    t_out_word          r_out;
    logic               r_out_valid;

    logic               t_full, c_full;
    logic signed [CMP_W-1:0] c_sx, c_sy, c_up, c_fa;
    logic [2:0]         n_posture;
    logic [31:0]        n_cstamp, n_elapsed;
    logic [15:0]        n_delay;
    logic               n_lifted, n_ready, n_moving;

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // window update
    assign t_full = (r_tcnt == TC_W'(TILT_WINDOW));
    assign c_full = (r_ccnt == CC_W'(CHARGE_WINDOW));

    always_comb begin
        n_xsum = r_xsum + TS_W'(r_in.tilt_x);
        n_ysum = r_ysum + TS_W'(r_in.tilt_y);
        n_csum = r_csum + CS_W'(r_in.battery_charge);
        if (t_full) begin
            n_xsum = n_xsum - TS_W'($signed(r_tilt_rd[31:16]));
            n_ysum = n_ysum - TS_W'($signed(r_tilt_rd[15:0]));
        end
        if (c_full) begin
            n_csum = n_csum - CS_W'(r_charge_rd);
        end
    end

    // posture class
    assign c_sx = CMP_W'(r_xsum);
    assign c_sy = CMP_W'(r_ysum);
    assign c_up = CMP_W'(r_up_n);
    assign c_fa = CMP_W'(r_fa_n);

    always_comb begin
        n_posture = POSTURE_UNDEFINED;
        if (c_sx < c_up && c_sx > -c_up && c_sy < c_up && c_sy > -c_up) begin
            n_posture = POSTURE_UPRIGHT;
        end
        if (c_sx < -c_fa) begin
            n_posture = POSTURE_LEFT;
        end else if (c_sx > c_fa) begin
            n_posture = POSTURE_RIGHT;
        end
        if (c_sy < -c_fa) begin
            n_posture = POSTURE_BACK;
        end else if (c_sy > c_fa) begin
            n_posture = POSTURE_FRONT;
        end
    end

    // contact and lift timing
    always_comb begin
        n_cstamp = r_contact_stamp;
        if (r_in.left_contact != r_left_held || r_in.right_contact != r_right_held) begin
            n_cstamp = r_in.frame_time;
        end
        n_moving  = (r_in.motion_kind == MOTION_WALK);
        n_delay   = n_moving ? r_delay_walking : r_delay_idle;
        n_elapsed = r_in.frame_time - n_cstamp;
        n_lifted  = (n_posture == POSTURE_UPRIGHT) && !r_in.left_contact
                    && !r_in.right_contact && !n_elapsed[31]
                    && (n_elapsed[30:0] > 31'(n_delay));
        n_ready   = (n_posture == POSTURE_UPRIGHT) && !n_lifted
                    && (n_moving || (r_in.motion_kind == MOTION_STAND
                                     && r_in.goal_met));
    end

    // window memories
    always_ff @(posedge i_clk) begin
        r_tilt_rd   <= r_tilt_mem[r_tslot];
        r_charge_rd <= r_charge_mem[r_cslot];
        if (r_state == S_SUM) begin
            r_tilt_mem[r_tslot]   <= {r_in.tilt_x, r_in.tilt_y};
            r_charge_mem[r_cslot] <= r_in.battery_charge;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upright_limit    <= RST_UPRIGHT_LIMIT;
            r_fallen_limit     <= RST_FALLEN_LIMIT;
            r_charging_current <= RST_CHARGING_CURRENT;
            r_delay_idle       <= RST_LIFT_DELAY;
            r_delay_walking    <= RST_LIFT_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_UPRIGHT_LIMIT:      r_upright_limit    <= i_cfg_data[14:0];
                CFG_FALLEN_LIMIT:       r_fallen_limit     <= i_cfg_data[14:0];
                CFG_CHARGING_CURRENT:   r_charging_current <= $signed(i_cfg_data);
                CFG_LIFT_DELAY_IDLE:    r_delay_idle       <= i_cfg_data;
                CFG_LIFT_DELAY_WALKING: r_delay_walking    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
        if (r_state == S_MUL) begin
            r_up_n  <= r_upright_limit * r_tcnt;
            r_fa_n  <= r_fallen_limit * r_tcnt;
            r_cprod <= r_csum * DV_MUL;
        end
        if (r_state == S_CLASS) begin
            r_res.posture        <= n_posture;
            r_res.posture_since  <= (n_posture != r_held_posture) ? r_in.frame_time
                                                                  : r_posture_stamp;
            r_res.left_standing  <= r_in.left_contact;
            r_res.right_standing <= r_in.right_contact;
            r_res.contact_since  <= n_cstamp;
            r_res.lifted         <= n_lifted;
            r_res.walk_ready     <= n_ready;
            r_res.discharging    <= (r_in.battery_current < DISCHARGE_LIMIT);
            r_res.charging       <= (r_in.battery_current >= r_charging_current);
            r_res.charge_level   <= c_full ? r_cprod[DV_SH +: CHARGE_W]
                                           : r_in.battery_charge;
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_xsum          <= '0;
            r_ysum          <= '0;
            r_tcnt          <= '0;
            r_tslot         <= '0;
            r_csum          <= '0;
            r_ccnt          <= '0;
            r_cslot         <= '0;
            r_held_posture  <= POSTURE_UNDEFINED;
            r_posture_stamp <= '0;
            r_left_held     <= 1'b0;
            r_right_held    <= 1'b0;
            r_contact_stamp <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_xsum  <= n_xsum;
                    r_ysum  <= n_ysum;
                    r_csum  <= n_csum;
                    r_tcnt  <= t_full ? r_tcnt : r_tcnt + TC_W'(1);
                    r_ccnt  <= c_full ? r_ccnt : r_ccnt + CC_W'(1);
                    r_tslot <= (r_tslot == TA_W'(TILT_WINDOW - 1)) ? '0
                                                                   : r_tslot + TA_W'(1);
                    r_cslot <= (r_cslot == CA_W'(CHARGE_WINDOW - 1)) ? '0
                                                                     : r_cslot + CA_W'(1);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    if (n_posture != r_held_posture) begin
                        r_posture_stamp <= r_in.frame_time;
                    end
                    r_held_posture  <= n_posture;
                    r_contact_stamp <= n_cstamp;
                    r_left_held     <= r_in.left_contact;
                    r_right_held    <= r_in.right_contact;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: verif/tb_body_posture_monitor.sv
// Testbench for body_posture_monitor: drives sensor words, predicts each result word
// and compares it field by field. Depends on bpm_pkg and the body_posture_monitor RTL.
`timescale 1ns / 1ps
module tb_body_posture_monitor;
    import bpm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_LIFT_DELAY_WALKING + 3'd1;

    class body_state_scoreboard;
        logic [14:0]        upright_lim;
        logic [14:0]        fallen_lim;
        logic signed [15:0] charge_thresh;
        logic [15:0]        delay_idle;
        logic [15:0]        delay_walk;

        int          tx_ring[DEF_TILT_WINDOW];
        int          ty_ring[DEF_TILT_WINDOW];
        longint      sx;
        longint      sy;
        int          tcount;
        int          tslot;
        int unsigned ch_ring[DEF_CHARGE_WINDOW];
        int unsigned ch_sum;
        int          ccount;
        int          cslot;
        logic [2:0]  held_posture;
        logic [31:0] posture_stamp;
        logic [31:0] contact_stamp;
        logic        left_held;
        logic        right_held;

        t_out_word pending_states[$];
        int        errors;

        function new();
            upright_lim   = RST_UPRIGHT_LIMIT;
            fallen_lim    = RST_FALLEN_LIMIT;
            charge_thresh = RST_CHARGING_CURRENT;
            delay_idle    = RST_LIFT_DELAY;
            delay_walk    = RST_LIFT_DELAY;
            sx = 0;
            sy = 0;
            tcount = 0;
            tslot = 0;
            ch_sum = 0;
            ccount = 0;
            cslot = 0;
            held_posture  = POSTURE_UNDEFINED;
            posture_stamp = '0;
            contact_stamp = '0;
            left_held  = 1'b0;
            right_held = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_UPRIGHT_LIMIT:      upright_lim   = data[14:0];
                CFG_FALLEN_LIMIT:       fallen_lim    = data[14:0];
                CFG_CHARGING_CURRENT:   charge_thresh = data;
                CFG_LIFT_DELAY_IDLE:    delay_idle    = data;
                CFG_LIFT_DELAY_WALKING: delay_walk    = data;
                default: ;
            endcase
        endfunction

        function longint mag64(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function void note_frame(t_in_word w);
            longint      up_bound;
            longint      fall_bound;
            logic [2:0]  p;
            logic [15:0] delay;
            logic [31:0] elapsed;
            logic        lifted;
            t_out_word   e;

            if (tcount >= DEF_TILT_WINDOW) begin
                sx -= longint'(tx_ring[tslot]);
                sy -= longint'(ty_ring[tslot]);
            end else begin
                tcount++;
            end
            tx_ring[tslot] = int'(w.tilt_x);
            ty_ring[tslot] = int'(w.tilt_y);
            sx += longint'(tx_ring[tslot]);
            sy += longint'(ty_ring[tslot]);
            tslot = (tslot + 1) % DEF_TILT_WINDOW;

            up_bound   = longint'(upright_lim) * tcount;
            fall_bound = longint'(fallen_lim) * tcount;
            p = POSTURE_UNDEFINED;
            if (mag64(sx) < up_bound && mag64(sy) < up_bound)
                p = POSTURE_UPRIGHT;
            if (sx < -fall_bound)
                p = POSTURE_LEFT;
            else if (sx > fall_bound)
                p = POSTURE_RIGHT;
            if (sy < -fall_bound)
                p = POSTURE_BACK;
            else if (sy > fall_bound)
                p = POSTURE_FRONT;
            if (p != held_posture)
                posture_stamp = w.frame_time;
            held_posture = p;

            if (w.left_contact != left_held || w.right_contact != right_held)
                contact_stamp = w.frame_time;
            left_held  = w.left_contact;
            right_held = w.right_contact;

            delay   = (w.motion_kind == MOTION_WALK) ? delay_walk : delay_idle;
            elapsed = w.frame_time - contact_stamp;
            lifted  = (p == POSTURE_UPRIGHT) && !w.left_contact && !w.right_contact &&
                      (longint'($signed(elapsed)) > longint'(delay));

            if (ccount >= DEF_CHARGE_WINDOW)
                ch_sum -= ch_ring[cslot];
            else
                ccount++;
            ch_ring[cslot] = 32'(w.battery_charge);
            ch_sum += 32'(w.battery_charge);
            cslot = (cslot + 1) % DEF_CHARGE_WINDOW;

            e.posture        = p;
            e.posture_since  = posture_stamp;
            e.left_standing  = left_held;
            e.right_standing = right_held;
            e.contact_since  = contact_stamp;
            e.lifted         = lifted;
            e.walk_ready     = (p == POSTURE_UPRIGHT) && !lifted &&
                               (w.motion_kind == MOTION_WALK ||
                                (w.motion_kind == MOTION_STAND && w.goal_met));
            e.discharging    = $signed(w.battery_current) < DISCHARGE_LIMIT;
            e.charging       = $signed(w.battery_current) >= charge_thresh;
            e.charge_level   = (ccount >= DEF_CHARGE_WINDOW) ?
                               CHARGE_W'(ch_sum / DEF_CHARGE_WINDOW) : w.battery_charge;
            pending_states.push_back(e);
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(t_out_word got);
            t_out_word e;
            if (pending_states.size() == 0) begin
                $error("result word with no pending expectation");
                errors++;
                return;
            end
            e = pending_states.pop_front();
            cmp("posture", 32'(e.posture), 32'(got.posture));
            cmp("posture_since", e.posture_since, got.posture_since);
            cmp("left_standing", 32'(e.left_standing), 32'(got.left_standing));
            cmp("right_standing", 32'(e.right_standing), 32'(got.right_standing));
            cmp("contact_since", e.contact_since, got.contact_since);
            cmp("lifted", 32'(e.lifted), 32'(got.lifted));
            cmp("walk_ready", 32'(e.walk_ready), 32'(got.walk_ready));
            cmp("discharging", 32'(e.discharging), 32'(got.discharging));
            cmp("charging", 32'(e.charging), 32'(got.charging));
            cmp("charge_level", 32'(e.charge_level), 32'(got.charge_level));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    body_state_scoreboard sb = new();
    logic [31:0] clock_ms;
    logic        calm;
    logic        idle_on;
    int          cycles;
    int          stall_left;

    body_posture_monitor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result side: check, then hold off at random
    initial begin
        stall_left = 0;
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_word(o_out_word);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0)
                    i_out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9);
                i_out_ready <= 1'b0;
            end
        end
    end

    function automatic t_in_word mk_frame(int tx, int ty, bit lc, bit rc, logic [31:0] t,
                                          logic [1:0] m, bit r, int cur, int chg);
        t_in_word w;
        w.tilt_x          = 16'(tx);
        w.tilt_y          = 16'(ty);
        w.left_contact    = lc;
        w.right_contact   = rc;
        w.frame_time      = t;
        w.motion_kind     = m;
        w.goal_met        = r;
        w.battery_current = 16'(cur);
        w.battery_charge  = CHARGE_W'(chg);
        return w;
    endfunction

    function automatic int sat16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int pick_edge(int ul, int fl);
        int v;
        case ($urandom_range(0, 3))
            0: v = ul;
            1: v = ul - 1;
            2: v = fl;
            default: v = fl + 1;
        endcase
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    task automatic push_frame(t_in_word w);
        int gap;
        gap = (!calm && idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_frame(w);
    endtask

    task automatic await_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_states.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic close_cfg();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_config();
        int ul;
        ul = $urandom_range(300, 6000);
        write_reg(CFG_UPRIGHT_LIMIT, 16'(ul) | 16'($urandom_range(0, 1) << 15));
        write_reg(CFG_FALLEN_LIMIT,
                  16'($urandom_range(ul, 14000)) | 16'($urandom_range(0, 1) << 15));
        write_reg(CFG_CHARGING_CURRENT, 16'($urandom_range(0, 65535)));
        write_reg(CFG_LIFT_DELAY_IDLE, 16'($urandom_range(0, 3000)));
        write_reg(CFG_LIFT_DELAY_WALKING, 16'($urandom_range(0, 3000)));
        if ($urandom_range(0, 1))
            write_reg(CFG_UNUSED_FIRST + 3'($urandom_range(0, 2)), 16'($urandom_range(0, 65535)));
        close_cfg();
    endtask

    task automatic run_scenes(int n_items, int calm_tail);
        int sent, len, kind, k, noise, bx, by, ul, fl, mode, tx, ty, cur, chg;
        bit lc, rc, reached;
        logic [1:0] mk;
        sent = 0;
        lc = 1'b1;
        rc = 1'b0;
        while (sent < n_items) begin
            kind  = $urandom_range(0, 7);
            len   = $urandom_range(4, 40);
            ul    = int'(sb.upright_lim);
            fl    = int'(sb.fallen_lim);
            noise = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 3000);
            bx = 0;
            by = 0;
            case (kind)
                0, 6: noise = $urandom_range(0, ul + 200);
                1: begin
                    bx = -fl - $urandom_range(0, 3000);
                    by = $urandom_range(0, fl) - fl / 2;
                end
                2: begin
                    bx = fl + $urandom_range(0, 3000);
                    by = $urandom_range(0, fl) - fl / 2;
                end
                3: begin
                    by = -fl - $urandom_range(0, 3000);
                    bx = $urandom_range(0, 2 * fl) - fl;
                end
                4: begin
                    by = fl + $urandom_range(0, 3000);
                    bx = $urandom_range(0, 2 * fl) - fl;
                end
                5: begin
                    bx = pick_edge(ul, fl);
                    by = pick_edge(ul, fl);
                    noise = $urandom_range(0, 1);
                end
                default: ;
            endcase
            mode    = $urandom_range(0, 3);
            mk      = 2'($urandom_range(0, 3));
            reached = 1'($urandom_range(0, 1));
            idle_on = $urandom_range(0, 2) != 0;
            for (k = 0; k < len && sent < n_items; k++) begin
                case ($urandom_range(0, 19))
                    0: clock_ms = clock_ms - 32'($urandom_range(1, 5000));
                    1: clock_ms = $urandom();
                    default: clock_ms = clock_ms + 32'($urandom_range(0, 400));
                endcase
                if (kind == 7) begin
                    tx = $urandom_range(0, 65535);
                    ty = $urandom_range(0, 65535);
                end else begin
                    tx = sat16(bx + int'($urandom_range(0, 2 * noise)) - noise);
                    ty = sat16(by + int'($urandom_range(0, 2 * noise)) - noise);
                end
                case (mode)
                    0: begin lc = 1'b1; rc = 1'b1; end
                    1: begin lc = 1'b0; rc = 1'b0; end
                    2: begin lc = 1'($urandom_range(0, 1)); rc = 1'($urandom_range(0, 1)); end
                    default: if ($urandom_range(0, 3) == 0) begin lc = ~lc; rc = ~lc; end
                endcase
                if ($urandom_range(0, 9) == 0)
                    mk = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 4) == 0)
                    reached = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0: cur = int'(DISCHARGE_LIMIT);
                    1: cur = int'(DISCHARGE_LIMIT) - 1;
                    2: cur = int'(sb.charge_thresh);
                    3: cur = int'(sb.charge_thresh) - 1;
                    default: cur = $urandom_range(0, 65535);
                endcase
                case ($urandom_range(0, 7))
                    0: chg = 0;
                    1: chg = 4095;
                    default: chg = $urandom_range(0, 4095);
                endcase
                calm = (sent >= n_items - calm_tail);
                push_frame(mk_frame(tx, ty, lc, rc, clock_ms, mk, reached, cur, chg));
                sent++;
            end
        end
    endtask

    initial begin
        calm        = 1'b0;
        idle_on     = 1'b1;
        clock_ms    = '0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extremes, every motion code, window fill, lift timing and wrap
        push_frame(mk_frame(0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_frame(mk_frame(32767, 32767, 1, 1, 10, MOTION_WALK, 1, 32767, 4095));
        push_frame(mk_frame(-32768, -32768, 1, 0, 20, MOTION_STAND, 1, -32768, 0));
        push_frame(mk_frame(0, 0, 0, 1, 30, 3, 1, DISCHARGE_LIMIT, 2048));
        push_frame(mk_frame(0, 0, 0, 0, 40, MOTION_STAND, 0, DISCHARGE_LIMIT - 1, 1));
        push_frame(mk_frame(0, 0, 0, 0, 440, MOTION_WALK, 0, -1, 4095));
        push_frame(mk_frame(0, 0, 0, 0, 840, MOTION_WALK, 1, 0, 4095));
        push_frame(mk_frame(0, 0, 0, 0, 1240, MOTION_STAND, 1, 1, 4095));
        push_frame(mk_frame(0, 0, 0, 0, 1640, MOTION_WALK, 0, 100, 3000));
        push_frame(mk_frame(0, 0, 0, 0, 2040, MOTION_STAND, 1, -501, 3000));
        push_frame(mk_frame(0, 0, 0, 0, 2440, 3, 1, -500, 3000));
        push_frame(mk_frame(0, 0, 0, 0, 2840, 0, 0, -499, 3000));
        push_frame(mk_frame(0, 0, 0, 0, 0, 0, 0, 5, 3000));
        push_frame(mk_frame(0, 0, 1, 0, 32'hFFFF_FC00, 0, 0, 5, 2000));
        push_frame(mk_frame(0, 0, 0, 0, 32'hFFFF_FE00, 0, 0, 5, 2000));
        push_frame(mk_frame(0, 0, 0, 0, 32'h0000_0400, 0, 0, 5, 2000));
        push_frame(mk_frame(0, 0, 0, 0, 32'h0000_0500, MOTION_STAND, 1, 5, 0));
        push_frame(mk_frame(-32768, 0, 1, 1, 32'h0000_0600, 0, 0, 5, 4095));
        push_frame(mk_frame(-32768, 0, 1, 1, 32'h0000_0700, 0, 0, 5, 4095));
        push_frame(mk_frame(-32768, 0, 1, 1, 32'h0000_0800, 0, 0, 5, 4095));
        push_frame(mk_frame(32767, 32767, 0, 1, 32'h0000_0900, 0, 0, 5, 1));
        push_frame(mk_frame(32767, 32767, 0, 1, 32'h0000_0A00, 0, 0, 5, 1));
        push_frame(mk_frame(32767, 32767, 0, 1, 32'h0000_0B00, 0, 0, 5, 1));
        clock_ms = 32'h0000_0B00;
        await_idle();

        random_config();
        run_scenes(150, 0);
        await_idle();

        write_reg(CFG_UPRIGHT_LIMIT, 16'hFFFF);
        write_reg(CFG_FALLEN_LIMIT, 16'h0000);
        write_reg(CFG_CHARGING_CURRENT, 16'h8000);
        write_reg(CFG_LIFT_DELAY_IDLE, 16'h0000);
        write_reg(CFG_LIFT_DELAY_WALKING, 16'hFFFF);
        write_reg(CFG_UNUSED_FIRST, 16'h0000);
        write_reg(CFG_UNUSED_FIRST + 3'd1, 16'hFFFF);
        write_reg(CFG_UNUSED_FIRST + 3'd2, 16'h5A5A);
        close_cfg();
        run_scenes(60, 0);
        await_idle();

        write_reg(CFG_UPRIGHT_LIMIT, 16'h0000);
        write_reg(CFG_FALLEN_LIMIT, 16'h7FFF);
        write_reg(CFG_CHARGING_CURRENT, 16'h7FFF);
        write_reg(CFG_LIFT_DELAY_IDLE, 16'hFFFF);
        write_reg(CFG_LIFT_DELAY_WALKING, 16'h0000);
        close_cfg();
        run_scenes(60, 0);
        await_idle();

        random_config();
        run_scenes(180, 60);
        i_in_valid <= 1'b0;
        while (sb.pending_states.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: files.f
rtl/bpm_pkg.sv
rtl/body_posture_monitor.sv
verif/tb_body_posture_monitor.sv
